/* rtl/ffa_pkg.sv */
// ffa_pkg: shared constants, codes and controller/datapath interface types
// for the first-fit heap allocator. No dependencies.
package ffa_pkg;

  localparam int HEAP_BYTES_DEF  = 65536;
  localparam int BLOCK_BYTES_DEF = 64;
  // header size is fixed; it must stay a power of two (offsets are shifts)
  localparam int HEADER_BYTES    = 16;
  localparam int HDR_SH          = 4;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;

  localparam logic REG_HEAP_START = 1'b0;
  localparam logic REG_HEAP_SIZE  = 1'b1;

  localparam logic [31:0] HEAP_START_RST = 32'd4096;
  localparam logic [16:0] HEAP_SIZE_RST  = 17'h10000;

  typedef logic [4:0] act_t;

  localparam act_t ACT_NONE       = 5'd0;
  localparam act_t ACT_LOAD       = 5'd1;
  localparam act_t ACT_A_START    = 5'd2;
  localparam act_t ACT_RD_CUR     = 5'd3;
  localparam act_t ACT_A_ADV      = 5'd4;
  localparam act_t ACT_A_TAKE     = 5'd5;
  localparam act_t ACT_A_W1       = 5'd6;
  localparam act_t ACT_A_W2       = 5'd7;
  localparam act_t ACT_A_W3       = 5'd8;
  localparam act_t ACT_F_START    = 5'd9;
  localparam act_t ACT_F_ADV      = 5'd10;
  localparam act_t ACT_F_LINK_N   = 5'd11;
  localparam act_t ACT_F_LINK_CUR = 5'd12;
  localparam act_t ACT_F_HEAD     = 5'd13;
  localparam act_t ACT_M_RD_A     = 5'd14;
  localparam act_t ACT_M_RD_B     = 5'd15;
  localparam act_t ACT_M_WR       = 5'd16;
  localparam act_t ACT_M_SET_CUR  = 5'd17;
  localparam act_t ACT_INIT       = 5'd18;
  localparam act_t ACT_SUCCESS    = 5'd19;
  localparam act_t ACT_FAIL       = 5'd20;
  localparam act_t ACT_EMIT       = 5'd21;

  typedef struct packed {
    logic [1:0] kind;
    logic       cnt_zero;
    logic       free_ok;
    logic       start_walk;
    logic       cur_valid;
    logic       limit;
    logic       fit;
    logic       split;
    logic       nx_more;
    logic       link_valid;
    logic       adjacent;
    logic       merge_more;
    logic       out_free;
  } stat_t;

endpackage

/* rtl/ffa_ram.sv */
// ffa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ffa_dpath.sv */
// ffa_dpath: allocator datapath: item and config registers, list pointers,
// header memories and result register. Depends on ffa_pkg and ffa_ram.
module ffa_dpath
  import ffa_pkg::*;
#(
  parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  act_t        act,
  output stat_t       st,
  input  logic [1:0]  kind,
  input  logic [10:0] block_count,
  input  logic [31:0] address,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] result_address,
  output logic        status
);

  localparam int SLOTS  = HEAP_BYTES / HEADER_BYTES;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LINK_W = SLOT_W + 1;
  localparam int SIZE_W = $clog2(HEAP_BYTES + 1);
  localparam int NEED_W = 11 + $clog2(BLOCK_BYTES);

  logic [1:0]        kind_q;
  logic              cnt_zero_q;
  logic [31:0]       addr_q;
  logic [NEED_W-1:0] need_q;
  logic [31:0]       heap_start;
  logic [16:0]       heap_size;
  logic              fh_v;
  logic [SLOT_W-1:0] fh_s;
  logic              init_q;
  logic              cur_v;
  logic [SLOT_W-1:0] cur_s;
  logic              prev_v;
  logic [SLOT_W-1:0] prev_s;
  logic [SLOT_W:0]   steps;
  logic [SLOT_W-1:0] b_s;
  logic [SIZE_W-1:0] size_b;
  logic [LINK_W-1:0] next_b;
  logic [SLOT_W-1:0] n_s;
  logic [SLOT_W-1:0] ma;
  logic [SIZE_W-1:0] sa;
  logic [SLOT_W-1:0] mb;
  logic              pass2;
  logic [31:0]       res_addr;
  logic              res_stat;

  // memory ports
  logic              nx_we, sz_we;
  logic [SLOT_W-1:0] nx_waddr, sz_waddr, raddr;
  logic [LINK_W-1:0] nx_wdata, nx_rd;
  logic [SIZE_W-1:0] sz_wdata, sz_rd;

  // derived values
  logic [31:0]       len;
  logic [31:0]       pay;
  logic [32:0]       lo_bound, hi_bound;
  logic [SLOT_W-1:0] n_free;
  logic [SIZE_W-1:0] rem;
  logic [31:0]       split_off;
  logic [SLOT_W-1:0] n_split;
  logic [31:0]       take_addr;
  logic              rd_nv;
  logic [SLOT_W-1:0] rd_ns;

  ffa_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(raddr), .rdata(nx_rd)
  );

  ffa_ram #(.WIDTH(SIZE_W), .DEPTH(SLOTS)) u_size (
    .clk(clk), .we(sz_we), .waddr(sz_waddr), .wdata(sz_wdata),
    .raddr(raddr), .rdata(sz_rd)
  );

  always_comb begin
    rd_nv     = nx_rd[SLOT_W];
    rd_ns     = nx_rd[SLOT_W-1:0];
    len       = (32'(heap_size) > 32'(HEAP_BYTES)) ? 32'(HEAP_BYTES) : 32'(heap_size);
    pay       = addr_q - heap_start;
    lo_bound  = {1'b0, heap_start} + 33'(HEADER_BYTES);
    hi_bound  = {1'b0, heap_start} + {1'b0, len};
    n_free    = pay[SLOT_W+HDR_SH-1:HDR_SH] - SLOT_W'(1);
    rem       = size_b - SIZE_W'(need_q);
    split_off = (32'(b_s) << HDR_SH) + 32'(HEADER_BYTES) + 32'(need_q);
    n_split   = split_off[SLOT_W+HDR_SH-1:HDR_SH];
    take_addr = heap_start + (32'(b_s) << HDR_SH) + 32'(HEADER_BYTES);

    st.kind       = kind_q;
    st.cnt_zero   = cnt_zero_q;
    st.free_ok    = (addr_q != 32'd0) && ({1'b0, addr_q} >= lo_bound) &&
                    ({1'b0, addr_q} < hi_bound) && (pay[HDR_SH-1:0] == '0);
    st.start_walk = fh_v && !(pay < (32'(fh_s) << HDR_SH));
    st.cur_valid  = cur_v;
    st.limit      = steps >= (SLOT_W+1)'(SLOTS);
    st.fit        = 32'(sz_rd) >= 32'(need_q);
    st.split      = 32'(rem) >= 32'(BLOCK_BYTES + HEADER_BYTES);
    st.nx_more    = rd_nv && (pay > (32'(rd_ns) << HDR_SH));
    st.link_valid = rd_nv;
    st.adjacent   = ((32'(ma) << HDR_SH) + 32'(sa) + 32'(HEADER_BYTES)) ==
                    (32'(mb) << HDR_SH);
    st.merge_more = !pass2 && cur_v;
    st.out_free   = !out_valid || out_ready;
  end

  // memory port steering
  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = ma;
    nx_wdata = '0;
    sz_we    = 1'b0;
    sz_waddr = ma;
    sz_wdata = '0;
    raddr    = cur_s;
    case (act)
      ACT_M_RD_A: raddr = ma;
      ACT_M_RD_B: raddr = rd_ns;
      ACT_M_WR: begin
        sz_we    = 1'b1;
        sz_wdata = sa + sz_rd + SIZE_W'(HEADER_BYTES);
        nx_we    = 1'b1;
        nx_wdata = nx_rd;
      end
      ACT_F_HEAD: begin
        nx_we    = 1'b1;
        nx_waddr = n_s;
        nx_wdata = {fh_v, fh_s};
      end
      ACT_F_LINK_N: begin
        nx_we    = 1'b1;
        nx_waddr = n_s;
        nx_wdata = nx_rd;
      end
      ACT_F_LINK_CUR: begin
        nx_we    = 1'b1;
        nx_waddr = cur_s;
        nx_wdata = {1'b1, n_s};
      end
      ACT_A_W1: begin
        if (st.split) begin
          sz_we    = 1'b1;
          sz_waddr = b_s;
          sz_wdata = SIZE_W'(need_q);
        end
        nx_we    = prev_v;
        nx_waddr = prev_s;
        nx_wdata = st.split ? {1'b1, n_split} : next_b;
      end
      ACT_A_W2: begin
        nx_we = 1'b1;
        if (st.split) begin
          nx_waddr = n_split;
          nx_wdata = next_b;
          sz_we    = 1'b1;
          sz_waddr = n_split;
          sz_wdata = rem - SIZE_W'(HEADER_BYTES);
        end else begin
          nx_waddr = b_s;
        end
      end
      ACT_A_W3: begin
        nx_we    = 1'b1;
        nx_waddr = b_s;
      end
      ACT_INIT: begin
        if (!init_q) begin
          nx_we    = 1'b1;
          nx_waddr = '0;
          sz_we    = 1'b1;
          sz_waddr = '0;
          sz_wdata = (len >= 32'(HEADER_BYTES)) ?
                     SIZE_W'(len - 32'(HEADER_BYTES)) : '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_start <= HEAP_START_RST;
      heap_size  <= HEAP_SIZE_RST;
      fh_v       <= 1'b0;
      fh_s       <= '0;
      init_q     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HEAP_START: heap_start <= cfg_data;
          REG_HEAP_SIZE:  heap_size  <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (act == ACT_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (act)
        ACT_A_W1: begin
          if (!prev_v) begin
            fh_v <= st.split ? 1'b1 : next_b[SLOT_W];
            fh_s <= st.split ? n_split : next_b[SLOT_W-1:0];
          end
        end
        ACT_F_HEAD: begin
          fh_v <= 1'b1;
          fh_s <= n_s;
        end
        ACT_INIT: begin
          if (!init_q) begin
            fh_v   <= 1'b1;
            fh_s   <= '0;
            init_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (act)
      ACT_LOAD: begin
        kind_q     <= kind;
        cnt_zero_q <= (block_count == 11'd0);
        addr_q     <= address;
        need_q     <= NEED_W'(block_count) * NEED_W'(BLOCK_BYTES);
      end
      ACT_A_START: begin
        cur_v  <= fh_v;
        cur_s  <= fh_s;
        prev_v <= 1'b0;
        steps  <= '0;
      end
      ACT_A_ADV: begin
        prev_v <= cur_v;
        prev_s <= cur_s;
        cur_v  <= rd_nv;
        cur_s  <= rd_ns;
        steps  <= steps + 1'b1;
      end
      ACT_A_TAKE: begin
        b_s    <= cur_s;
        size_b <= sz_rd;
        next_b <= nx_rd;
      end
      ACT_A_W2: begin
        if (!st.split) begin
          res_addr <= take_addr;
          res_stat <= (take_addr == 32'd0);
        end
      end
      ACT_A_W3: begin
        res_addr <= take_addr;
        res_stat <= (take_addr == 32'd0);
      end
      ACT_F_START: begin
        cur_v <= st.start_walk;
        cur_s <= fh_s;
        steps <= '0;
        n_s   <= n_free;
      end
      ACT_F_ADV: begin
        cur_v <= rd_nv;
        cur_s <= rd_ns;
        steps <= steps + 1'b1;
      end
      ACT_F_HEAD, ACT_F_LINK_CUR: begin
        ma    <= n_s;
        pass2 <= 1'b0;
      end
      ACT_M_RD_B: begin
        sa <= sz_rd;
        mb <= rd_ns;
      end
      ACT_M_SET_CUR: begin
        ma    <= cur_s;
        pass2 <= 1'b1;
      end
      ACT_INIT, ACT_SUCCESS: begin
        res_addr <= '0;
        res_stat <= 1'b0;
      end
      ACT_FAIL: begin
        res_addr <= '0;
        res_stat <= 1'b1;
      end
      ACT_EMIT: begin
        result_address <= res_addr;
        status         <= res_stat;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/ffa_ctrl.sv */
// ffa_ctrl: sequencer for allocate, free (walk, link, up to two merges) and init.
// Depends on ffa_pkg; drives ffa_dpath through one action code per cycle.
module ffa_ctrl
  import ffa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output act_t  act
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DISPATCH   = 4'd1;
  localparam logic [3:0] S_A_CHECK    = 4'd2;
  localparam logic [3:0] S_A_WAIT     = 4'd3;
  localparam logic [3:0] S_A_W1       = 4'd4;
  localparam logic [3:0] S_A_W2       = 4'd5;
  localparam logic [3:0] S_A_W3       = 4'd6;
  localparam logic [3:0] S_F_CHECK    = 4'd7;
  localparam logic [3:0] S_F_WAIT     = 4'd8;
  localparam logic [3:0] S_F_INS      = 4'd9;
  localparam logic [3:0] S_F_INS_WAIT = 4'd10;
  localparam logic [3:0] S_F_INS2     = 4'd11;
  localparam logic [3:0] S_M_RD_A     = 4'd12;
  localparam logic [3:0] S_M_WAIT_A   = 4'd13;
  localparam logic [3:0] S_M_WAIT_B   = 4'd14;
  localparam logic [3:0] S_M_NEXT     = 4'd15;
  localparam logic [4:0] S_DONE       = 5'd16;

  logic [4:0] state, state_next;

  assign in_ready = (state == 5'(S_IDLE));

  always_comb begin
    state_next = state;
    act        = ACT_NONE;
    case (state)
      5'(S_IDLE): begin
        if (in_valid) begin
          act        = ACT_LOAD;
          state_next = 5'(S_DISPATCH);
        end
      end
      5'(S_DISPATCH): begin
        state_next = S_DONE;
        case (st.kind)
          KIND_ALLOC: begin
            if (st.cnt_zero) begin
              act = ACT_FAIL;
            end else begin
              act        = ACT_A_START;
              state_next = 5'(S_A_CHECK);
            end
          end
          KIND_FREE: begin
            if (!st.free_ok) begin
              act = ACT_FAIL;
            end else begin
              act        = ACT_F_START;
              state_next = st.start_walk ? 5'(S_F_CHECK) : 5'(S_F_INS);
            end
          end
          KIND_INIT: act = ACT_INIT;
          default:   act = ACT_FAIL;
        endcase
      end
      5'(S_A_CHECK): begin
        if (!st.cur_valid || st.limit) begin
          act        = ACT_FAIL;
          state_next = S_DONE;
        end else begin
          act        = ACT_RD_CUR;
          state_next = 5'(S_A_WAIT);
        end
      end
      5'(S_A_WAIT): begin
        if (st.fit) begin
          act        = ACT_A_TAKE;
          state_next = 5'(S_A_W1);
        end else begin
          act        = ACT_A_ADV;
          state_next = 5'(S_A_CHECK);
        end
      end
      5'(S_A_W1): begin
        act        = ACT_A_W1;
        state_next = 5'(S_A_W2);
      end
      5'(S_A_W2): begin
        act        = ACT_A_W2;
        state_next = st.split ? 5'(S_A_W3) : S_DONE;
      end
      5'(S_A_W3): begin
        act        = ACT_A_W3;
        state_next = S_DONE;
      end
      5'(S_F_CHECK): begin
        if (st.limit) begin
          state_next = 5'(S_F_INS);
        end else begin
          act        = ACT_RD_CUR;
          state_next = 5'(S_F_WAIT);
        end
      end
      5'(S_F_WAIT): begin
        if (st.nx_more) begin
          act        = ACT_F_ADV;
          state_next = 5'(S_F_CHECK);
        end else begin
          state_next = 5'(S_F_INS);
        end
      end
      5'(S_F_INS): begin
        if (st.cur_valid) begin
          act        = ACT_RD_CUR;
          state_next = 5'(S_F_INS_WAIT);
        end else begin
          act        = ACT_F_HEAD;
          state_next = 5'(S_M_RD_A);
        end
      end
      5'(S_F_INS_WAIT): begin
        act        = ACT_F_LINK_N;
        state_next = 5'(S_F_INS2);
      end
      5'(S_F_INS2): begin
        act        = ACT_F_LINK_CUR;
        state_next = 5'(S_M_RD_A);
      end
      5'(S_M_RD_A): begin
        act        = ACT_M_RD_A;
        state_next = 5'(S_M_WAIT_A);
      end
      5'(S_M_WAIT_A): begin
        if (st.link_valid) begin
          act        = ACT_M_RD_B;
          state_next = 5'(S_M_WAIT_B);
        end else begin
          state_next = 5'(S_M_NEXT);
        end
      end
      5'(S_M_WAIT_B): begin
        if (st.adjacent) begin
          act = ACT_M_WR;
        end
        state_next = 5'(S_M_NEXT);
      end
      5'(S_M_NEXT): begin
        if (st.merge_more) begin
          act        = ACT_M_SET_CUR;
          state_next = 5'(S_M_RD_A);
        end else begin
          act        = ACT_SUCCESS;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          act        = ACT_EMIT;
          state_next = 5'(S_IDLE);
        end
      end
      default: state_next = 5'(S_IDLE);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= 5'(S_IDLE);
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/first_fit_heap_allocator_core.sv */
// first_fit_heap_allocator_core: top level of the first-fit heap allocator.
// Depends on ffa_pkg, ffa_ctrl, ffa_dpath (which holds two ffa_ram).
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one item: kind (0 alloc,
//    1 free, 2 init, 3 no-op), block_count and address. Output channel
//    (out_valid/out_ready) returns one item per input: result_address and
//    status (0 ok, 1 fail).
//  - Config port: cfg_we with cfg_index 0 writes heap_start, index 1 writes
//    heap_size (cfg_data[16:0]). Write only while the block is idle.
//  - One item at a time. Cost is set by the free-list walk through the
//    header memories (registered read, each node visited is read and then
//    tested); init, no-op and rejected items do not walk the list.
//  - The result sits in an output register; the next item is accepted once
//    the result is loaded, even if the receiver has not taken it yet. While
//    the receiver stalls a second result waits in the sequencer.
//  - Reset: heap_start = 4096, heap_size = 65536, empty free list, not
//    initialised. Header memories are not cleared; they are undefined until
//    written (init writes the first header).
module first_fit_heap_allocator_core
  import ffa_pkg::*;
#(
  parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [10:0] block_count,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_address,
  output logic        status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  act_t  act;
  stat_t st;

  // sequencer: one action per cycle
  ffa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .st(st), .act(act)
  );

  // list pointers, header memories, config and result registers
  ffa_dpath #(.HEAP_BYTES(HEAP_BYTES), .BLOCK_BYTES(BLOCK_BYTES)) u_dpath (
    .clk(clk), .rst(rst), .act(act), .st(st),
    .kind(kind), .block_count(block_count), .address(address),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_ready(out_ready), .out_valid(out_valid),
    .result_address(result_address), .status(status)
  );

endmodule

/* tb/sv/tb.sv */
// tb: self-checking testbench for first_fit_heap_allocator_core.
// Depends on ffa_pkg and the allocator RTL. It predicts every result from its own
// heap model and checks the results in order through valid/ready handshakes.
module tb
  import ffa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_NOP = 2'd3;   // package has no code for the no-op kind
  localparam int SLOTS     = 4096;          // one header slot per 16 bytes of heap
  localparam int BLK       = 64;
  localparam int HDR       = 16;
  localparam int LIMIT     = 3_000_000;
  localparam int DRAIN     = 60;            // quiet cycles before a register write / end

  typedef struct {
    logic [1:0]  kind;
    logic [10:0] count;
    logic [31:0] addr;
  } op_t;

  typedef struct {
    logic [31:0] addr;
    logic        st;
  } res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic [10:0] block_count = '0;
  logic [31:0] address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result_address;
  logic        status;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  first_fit_heap_allocator_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .block_count(block_count), .address(address),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_address(result_address), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Heap model: its own copy of registers, header memories and free list.
  // A link is {valid, slot index}.
  // ---------------------------------------------------------------------------
  logic [31:0]  m_start = HEAP_START_RST;
  logic [16:0]  m_size  = HEAP_SIZE_RST;
  logic [12:0]  hdr_link [SLOTS];
  int unsigned  hdr_len  [SLOTS];
  bit           len_known[SLOTS];   // size entry written at least once
  logic [12:0]  head = '0;
  bit           heap_ready = 0;
  int           live_slots[$];      // payloads handed out and not yet freed

  op_t  pending_ops[$];
  res_t owed_results[$];

  int n_sent = 0, n_taken = 0, n_results = 0, n_bad = 0;
  int n_alloc_ok = 0, n_free_ok = 0;
  int send_idle = 0, recv_idle = 0;
  int cycles = 0;
  bit in_fired = 0;

  function automatic longint unsigned heap_span();
    return (m_size > HEAP_BYTES_DEF) ? HEAP_BYTES_DEF : m_size;
  endfunction

  function automatic void merge_with_next(logic [12:0] lnk);
    logic [11:0] a, b;
    if (!lnk[12]) return;
    a = lnk[11:0];
    if (!hdr_link[a][12]) return;
    b = hdr_link[a][11:0];
    if (longint'(a) * HDR + hdr_len[a] + HDR == longint'(b) * HDR) begin
      hdr_len[a]  = hdr_len[a] + hdr_len[b] + HDR;
      hdr_link[a] = hdr_link[b];
    end
  endfunction

  function automatic logic [31:0] heap_alloc(int unsigned cnt);
    logic [12:0] prev, cur;
    logic [11:0] b, n;
    longint unsigned need, rem;
    int steps;
    bit found;
    prev = '0; cur = head; steps = 0; found = 0;
    if (cnt == 0) return '0;
    need = longint'(cnt) * BLK;
    while (cur[12] && steps < SLOTS) begin
      if (hdr_len[cur[11:0]] >= need) begin
        found = 1;
        break;
      end
      prev = cur;
      cur = hdr_link[cur[11:0]];
      steps++;
    end
    if (!found) return '0;
    b = cur[11:0];
    rem = hdr_len[b] - need;
    if (rem >= BLK + HDR) begin
      // split: the tail becomes a new free block right after the payload
      n = 12'((longint'(b) * HDR + HDR + need) / HDR);
      hdr_len[b] = 32'(need);
      if (prev[12]) hdr_link[prev[11:0]] = {1'b1, n};
      else head = {1'b1, n};
      hdr_link[n] = hdr_link[b];
      hdr_len[n] = 32'(rem - HDR);
      len_known[n] = 1;
    end else begin
      if (prev[12]) hdr_link[prev[11:0]] = hdr_link[b];
      else head = hdr_link[b];
    end
    hdr_link[b] = '0;
    live_slots.push_back(b);
    return 32'(longint'(m_start) + longint'(b) * HDR + HDR);
  endfunction

  function automatic bit heap_free(logic [31:0] adr);
    longint unsigned a, hs, noff, pay;
    logic [11:0] n;
    logic [12:0] cur, nx;
    int steps;
    a = adr; hs = m_start; cur = '0; steps = 0;
    if (a == 0 || a < hs + HDR || a >= hs + heap_span()) return 0;
    if ((a - hs) % HDR != 0) return 0;
    noff = a - hs - HDR;
    pay = noff + HDR;
    n = 12'(noff / HDR);
    if (head[12] && !(pay < longint'(head[11:0]) * HDR)) begin
      cur = head;
      while (steps < SLOTS) begin
        nx = hdr_link[cur[11:0]];
        if (!nx[12] || !(pay > longint'(nx[11:0]) * HDR)) break;
        cur = nx;
        steps++;
      end
    end
    if (cur[12]) begin
      hdr_link[n] = hdr_link[cur[11:0]];
      hdr_link[cur[11:0]] = {1'b1, n};
    end else begin
      hdr_link[n] = head;
      head = {1'b1, n};
    end
    merge_with_next({1'b1, n});
    merge_with_next(cur);
    foreach (live_slots[i])
      if (live_slots[i] == n) begin
        live_slots.delete(i);
        break;
      end
    return 1;
  endfunction

  function automatic void heap_init();
    longint unsigned len;
    if (heap_ready) return;
    len = heap_span();
    hdr_link[0] = '0;
    hdr_len[0] = (len >= HDR) ? 32'(len - HDR) : 0;
    len_known[0] = 1;
    head = {1'b1, 12'd0};
    heap_ready = 1;
  endfunction

  function automatic res_t heap_step(op_t op);
    res_t r;
    r.addr = '0;
    r.st = 1'b1;
    case (op.kind)
      KIND_ALLOC: begin
        r.addr = heap_alloc(op.count);
        r.st = (r.addr == 0);
        if (!r.st) n_alloc_ok++;
      end
      KIND_FREE: begin
        r.st = !heap_free(op.addr);
        if (!r.st) n_free_ok++;
      end
      KIND_INIT: begin
        heap_init();
        r.st = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit on_free_list(int s);
    logic [12:0] p;
    p = head;
    for (int i = 0; i < SLOTS && p[12]; i++) begin
      if (p[11:0] == s) return 1;
      p = hdr_link[p[11:0]];
    end
    return 0;
  endfunction

  function automatic logic [31:0] slot_addr(int s);
    return 32'(longint'(m_start) + longint'(s) * HDR + HDR);
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    n_bad++;
    $display("[%0t] result %0d: %s expected 0x%08h got 0x%08h", $realtime, n_results,
             what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: takes pending items, holds valid and payload until accepted; randomises out_ready.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    op_t op;
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_fired) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle) begin
          op = pending_ops.pop_front();
          in_valid    <= 1'b1;
          kind        <= op.kind;
          block_count <= op.count;
          address     <= op.addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor: predicts on input acceptance, checks on output acceptance.
  always @(posedge clk) begin
    op_t  op;
    res_t want;
    in_fired <= in_valid && in_ready;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles,
               owed_results.size());
      $display("end of test: mismatches");
      $finish;
    end else if (!rst) begin
      if (in_valid && in_ready) begin
        op.kind = kind;
        op.count = block_count;
        op.addr = address;
        owed_results.push_back(heap_step(op));
        n_taken++;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (owed_results.size() == 0) begin
          flag_mismatch("result with nothing owed", 0, result_address);
        end else begin
          want = owed_results.pop_front();
          if (result_address !== want.addr)
            flag_mismatch("result_address", want.addr, result_address);
          if (status !== want.st)
            flag_mismatch("status", 32'(want.st), 32'(status));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Queue one item and wait until the block has taken it, so the next choice
  // is made against the model state it will really meet.
  task automatic send(logic [1:0] k, int unsigned cnt, logic [31:0] adr);
    op_t op;
    op.kind = k;
    op.count = 11'(cnt);
    op.addr = adr;
    pending_ops.push_back(op);
    n_sent++;
    do @(negedge clk); while (n_taken != n_sent);
  endtask

  task automatic settle();
    while (owed_results.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  // Register writes happen only while nothing is in flight.
  task automatic write_reg(logic idx, logic [31:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HEAP_START) m_start = val;
    else m_size = val[16:0];
  endtask

  task automatic free_live(int pick);
    int s;
    s = live_slots[pick];
    send(KIND_FREE, $urandom_range(2047), slot_addr(s));
  endtask

  // Random traffic: mostly well-formed allocate/free churn, some noise.
  task automatic churn(int items);
    int r, s, tries;
    int unsigned cnt;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (live_slots.size() > 40 && r < 45) r = r + 45;
      if (r < 45) begin
        r = $urandom_range(99);
        if (r < 70) cnt = $urandom_range(8, 1);
        else if (r < 90) cnt = $urandom_range(64, 9);
        else if (r < 97) cnt = $urandom_range(1024, 65);
        else if (r < 99) cnt = 0;
        else cnt = $urandom_range(2047, 1025);
        send(KIND_ALLOC, cnt, $urandom());
      end else if (r < 87 && live_slots.size() > 0) begin
        free_live($urandom_range(live_slots.size() - 1));
      end else if (r < 90) begin
        // stale header inside a merged or allocated region, never one on the list
        s = -1;
        for (tries = 0; tries < 20 && s < 0; tries++) begin
          s = $urandom_range(SLOTS - 1);
          if (!len_known[s] || on_free_list(s)) s = -1;
        end
        if (s >= 0) send(KIND_FREE, 0, slot_addr(s));
        else send(KIND_FREE, 0, 32'd0);
      end else if (r < 96) begin
        // addresses that must be refused: random, misaligned, out of range
        case ($urandom_range(3))
          0: send(KIND_FREE, 0, $urandom() | 32'h8000_0001);
          1: send(KIND_FREE, 0, slot_addr($urandom_range(200)) + $urandom_range(15, 1));
          2: send(KIND_FREE, 0, m_start + 32'($urandom_range(15)));
          default: send(KIND_FREE, 0, 32'(longint'(m_start) + heap_span()));
        endcase
      end else if (r < 98) begin
        send(KIND_INIT, $urandom_range(2047), $urandom());
      end else begin
        send(KIND_NOP, $urandom_range(2047), $urandom());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int a, b, c;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(REG_HEAP_START, 32'd4096);
    write_reg(REG_HEAP_SIZE, 32'h0001_0000);

    // before init: empty list, refused frees, no-op
    send(KIND_ALLOC, 5, 32'd0);
    send(KIND_NOP, 11'h7FF, 32'hFFFF_FFFF);
    send(KIND_FREE, 0, 32'd0);
    send(KIND_FREE, 0, 32'hFFFF_FFFF);
    send(KIND_INIT, 0, 32'd0);
    send(KIND_INIT, 0, 32'd0);            // repeated init is harmless
    send(KIND_ALLOC, 0, 32'd0);           // zero count fails
    send(KIND_ALLOC, 1024, 32'd0);        // larger than the whole heap
    send(KIND_ALLOC, 1023, 32'd0);        // fits, remainder too small to split
    free_live(0);
    send(KIND_ALLOC, 1, 32'd0);           // split off the front
    send(KIND_ALLOC, 2047, 32'd0);
    send(KIND_FREE, 0, slot_addr(live_slots[0]) + 8);   // misaligned
    send(KIND_FREE, 0, 32'd4096);                       // below first payload
    send(KIND_FREE, 0, 32'd4096 + 32'd65536);           // at heap end
    free_live(0);
    send(KIND_ALLOC, 3, 32'd0);
    send(KIND_ALLOC, 3, 32'd0);
    send(KIND_ALLOC, 3, 32'd0);
    a = live_slots[0]; b = live_slots[1]; c = live_slots[2];
    send(KIND_FREE, 0, slot_addr(b));     // lone hole in the middle
    send(KIND_FREE, 0, slot_addr(a));     // merges with its successor
    send(KIND_FREE, 0, slot_addr(c));     // merges on both sides

    // sender rarely idle, receiver often stalled
    send_idle = 7; recv_idle = 47;
    churn(440);
    settle();                             // sender holds off until all results are in

    write_reg(REG_HEAP_START, 32'd0);
    write_reg(REG_HEAP_SIZE, 32'h0001_FFFF);   // above capacity, clamps
    send_idle = 47; recv_idle = 7;
    churn(440);

    write_reg(REG_HEAP_START, 32'h7FFF_0008);  // unaligned base
    write_reg(REG_HEAP_SIZE, 32'($urandom_range(65536, 32)));
    send_idle = 0; recv_idle = 0;
    churn(430);

    write_reg(REG_HEAP_START, 32'hFFFF_FFF0);  // payload addresses wrap through zero
    write_reg(REG_HEAP_SIZE, 32'd32);
    churn(430);

    // corrupt list on purpose at the very end: a double free
    write_reg(REG_HEAP_START, 32'd4096);
    write_reg(REG_HEAP_SIZE, 32'h0001_0000);
    send(KIND_ALLOC, 1, 32'd0);
    if (live_slots.size() > 0) begin
      a = live_slots[live_slots.size() - 1];
      send(KIND_FREE, 0, slot_addr(a));
      send(KIND_FREE, 0, slot_addr(a));
    end
    send(KIND_ALLOC, 1, 32'd0);
    send(KIND_ALLOC, 2, 32'd0);

    settle();
    $display("covered %0d items: %0d allocations and %0d frees succeeded, %0d results checked",
             n_taken, n_alloc_ok, n_free_ok, n_results);
    $display("register settings: four heap bases incl. 0 and wrap, sizes 32 to above capacity");
    if (n_bad == 0 && owed_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
